// ----- sv/fcsg_pkg.sv -----
`timescale 1ns / 1ps

package fcsg_pkg;

    // Field widths
    localparam int COORD_W     = 12;   // centre coordinates, signed
    localparam int RAD_W       = 7;    // radius field, unsigned
    localparam int SPAN_W      = 13;   // span columns and rows, signed
    localparam int IN_TDATA_W  = 32;   // 31 payload bits padded to 4 bytes
    localparam int OUT_TDATA_W = 8 * SPAN_W;

    // Walk datapath widths, sized for radii up to 90
    localparam int OFS_W  = 7;    // x and y offsets
    localparam int TERM_W = 9;    // odd increments tx, ty (up to 2*90+3)
    localparam int ERR_W  = 11;   // signed error term
    localparam int DIAM_W = 8;    // 2 * radius

    // Result cap per circle
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int DEF_MAX_RADIUS = 64;

    typedef struct packed {
        logic        [OFS_W-1:0]  x;
        logic        [OFS_W-1:0]  y;
        logic        [TERM_W-1:0] tx;
        logic        [TERM_W-1:0] ty;
        logic signed [ERR_W-1:0]  err;
    } t_walk;

endpackage

// ----- sv/fcsg_step.sv -----
`timescale 1ns / 1ps

// One midpoint recurrence step: y move, then x move, plus end-of-walk test.
module fcsg_step (
    input  fcsg_pkg::t_walk                 i_cur,
    input  logic [fcsg_pkg::DIAM_W-1:0]     i_diam,
    input  logic [fcsg_pkg::CNT_W-1:0]      i_count,
    output fcsg_pkg::t_walk                 o_next,
    output logic [fcsg_pkg::CNT_W-1:0]      o_count,
    output logic                            o_last
);

    logic                                   w_move_y;
    logic                                   w_move_x;
    logic signed [fcsg_pkg::ERR_W-1:0]      w_err1;
    logic        [fcsg_pkg::TERM_W-1:0]     w_tx2;
    logic signed [fcsg_pkg::ERR_W-1:0]      w_dterm;

    always_comb begin
        o_next = i_cur;

        // err <= 0
        w_move_y = i_cur.err[fcsg_pkg::ERR_W-1] || (i_cur.err == '0);
        w_err1   = i_cur.err;
        if (w_move_y) begin
            o_next.y = i_cur.y + fcsg_pkg::OFS_W'(1);
            o_next.ty = i_cur.ty + fcsg_pkg::TERM_W'(2);
            w_err1 = i_cur.err + $signed({{(fcsg_pkg::ERR_W-fcsg_pkg::TERM_W){1'b0}}, i_cur.ty});
        end

        // err > 0 after the y move
        w_move_x = !w_err1[fcsg_pkg::ERR_W-1] && (w_err1 != '0);
        w_tx2    = i_cur.tx + fcsg_pkg::TERM_W'(2);
        w_dterm  = $signed({{(fcsg_pkg::ERR_W-fcsg_pkg::TERM_W){1'b0}}, w_tx2})
                 - $signed({{(fcsg_pkg::ERR_W-fcsg_pkg::DIAM_W){1'b0}}, i_diam});
        o_next.err = w_err1;
        if (w_move_x) begin
            o_next.x   = i_cur.x - fcsg_pkg::OFS_W'(1);
            o_next.tx  = w_tx2;
            o_next.err = w_err1 + w_dterm;
        end

        o_count = i_count + fcsg_pkg::CNT_W'(1);
        o_last  = (o_next.x < o_next.y)
               || (o_count >= fcsg_pkg::CNT_W'(fcsg_pkg::MAX_RESULTS));
    end

endmodule

// ----- sv/fcsg_span.sv -----
`timescale 1ns / 1ps

// Span adders and the output register of the result stream.
module fcsg_span (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic                                i_last,
    input  logic signed [fcsg_pkg::COORD_W-1:0] i_cx,
    input  logic signed [fcsg_pkg::COORD_W-1:0] i_cy,
    input  logic        [fcsg_pkg::OFS_W-1:0]   i_x,
    input  logic        [fcsg_pkg::OFS_W-1:0]   i_y,
    input  logic                                i_m_axis_tready,
    output logic                                o_m_axis_tvalid,
    output logic [fcsg_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);

    localparam int CPAD = fcsg_pkg::SPAN_W - fcsg_pkg::COORD_W;
    localparam int OPAD = fcsg_pkg::SPAN_W - fcsg_pkg::OFS_W;

    logic [fcsg_pkg::SPAN_W-1:0]      w_cx;
    logic [fcsg_pkg::SPAN_W-1:0]      w_cy;
    logic [fcsg_pkg::SPAN_W-1:0]      w_x;
    logic [fcsg_pkg::SPAN_W-1:0]      w_y;
    logic [fcsg_pkg::OUT_TDATA_W-1:0] w_spans;

    logic                             r_valid;
    logic                             r_last;
    logic [fcsg_pkg::OUT_TDATA_W-1:0] r_data;

    assign w_cx = {{CPAD{i_cx[fcsg_pkg::COORD_W-1]}}, i_cx};
    assign w_cy = {{CPAD{i_cy[fcsg_pkg::COORD_W-1]}}, i_cy};
    assign w_x  = {{OPAD{1'b0}}, i_x};
    assign w_y  = {{OPAD{1'b0}}, i_y};

    // Lowest first: wide L/R, wide rows below/above, narrow L/R, narrow rows
    assign w_spans = {w_cy - w_x, w_cy + w_x, w_cx + w_y, w_cx - w_y,
                      w_cy - w_y, w_cy + w_y, w_cx + w_x, w_cx - w_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= w_spans;
            r_last <= i_last;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;
    assign o_m_axis_tlast  = r_last;

endmodule

// ----- sv/filled_circle_span_generator.sv -----
`timescale 1ns / 1ps

// Filled circle span generator. Each input transaction carries a circle
// request (centre x, centre y, radius); the block walks the midpoint circle
// recurrence from x = radius-1, y = 0 while x >= y and sends one output
// transaction per step with two span pairs: wide spans cx-x..cx+x on rows
// cy+y and cy-y, narrow spans cx-y..cx+y on rows cy+x and cy-x. tlast marks
// the final step. A radius of 0 yields nothing; radii above MAX_RADIUS are
// clamped to it, and a walk is cut at 64 steps (tlast set on the 64th).
// No clipping, no de-duplication. Timing: the request is taken in the idle
// state, then the walk advances one step per cycle through the single
// recurrence step unit when the output side keeps up; output stalls hold
// the walk in place. The input side is ready only between circles; the
// last result of a circle may still be waiting on the output register
// while the next request is taken. Outputs are registered.
module filled_circle_span_generator #(
    parameter int MAX_RADIUS = fcsg_pkg::DEF_MAX_RADIUS   // 1..90
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [11:0] centre_x, [23:12] centre_y, [30:24] circle_radius, [31] zero
    input  logic [fcsg_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // Span stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [12:0] wide_left, [25:13] wide_right, [38:26] wide_row_below,
    // [51:39] wide_row_above, [64:52] narrow_left, [77:65] narrow_right,
    // [90:78] narrow_row_below, [103:91] narrow_row_above
    output logic [fcsg_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                                o_m_axis_tlast    // last_step
);

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    localparam int CW = fcsg_pkg::COORD_W;
    localparam int RW = fcsg_pkg::RAD_W;

    t_state                           r_state;
    fcsg_pkg::t_walk                  r_walk;
    logic signed [CW-1:0]             r_cx;
    logic signed [CW-1:0]             r_cy;
    logic [fcsg_pkg::DIAM_W-1:0]      r_diam;
    logic [fcsg_pkg::CNT_W-1:0]       r_count;

    // Request unpack
    logic signed [CW-1:0]             w_in_cx;
    logic signed [CW-1:0]             w_in_cy;
    logic [RW-1:0]                    w_in_rad;
    logic [RW-1:0]                    w_rad;
    logic [fcsg_pkg::DIAM_W-1:0]      w_diam;

    logic                             w_accept;
    logic                             w_fire;
    fcsg_pkg::t_walk                  w_next;
    logic [fcsg_pkg::CNT_W-1:0]       w_next_count;
    logic                             w_last;

    assign w_in_cx  = i_s_axis_tdata[CW-1:0];
    assign w_in_cy  = i_s_axis_tdata[2*CW-1:CW];
    assign w_in_rad = i_s_axis_tdata[2*CW+RW-1:2*CW];

    // Clamp radius
    assign w_rad  = (w_in_rad > RW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : w_in_rad;
    assign w_diam = {w_rad, 1'b0};

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // In the walk state, advance one step whenever the output register is free or draining
    assign w_fire = (r_state == ST_WALK) && (!o_m_axis_tvalid || i_m_axis_tready);

    fcsg_step u_step (
        .i_cur   (r_walk),
        .i_diam  (r_diam),
        .i_count (r_count),
        .o_next  (w_next),
        .o_count (w_next_count),
        .o_last  (w_last)
    );

    fcsg_span u_span (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_fire),
        .i_last          (w_last),
        .i_cx            (r_cx),
        .i_cy            (r_cy),
        .i_x             (r_walk.x),
        .i_y             (r_walk.y),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_cx        <= w_in_cx;
                        r_cy        <= w_in_cy;
                        r_diam      <= w_diam;
                        r_count     <= '0;
                        r_walk.x    <= fcsg_pkg::OFS_W'(w_rad - RW'(1));
                        r_walk.y    <= '0;
                        r_walk.tx   <= fcsg_pkg::TERM_W'(1);
                        r_walk.ty   <= fcsg_pkg::TERM_W'(1);
                        r_walk.err  <= fcsg_pkg::ERR_W'(1) - {
                            {(fcsg_pkg::ERR_W-fcsg_pkg::DIAM_W){1'b0}}, w_diam};
                        // zero radius: nothing to walk
                        if (w_in_rad != '0) begin
                            r_state <= ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    if (w_fire) begin
                        r_walk  <= w_next;
                        r_count <= w_next_count;
                        if (w_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
